### rtl/core/orm_pkg.sv
// orm_pkg: shared types, codes and defaults for the orientation rotate/mirror buffer
// no dependencies; imported by the interfaces, controller, datapath and top level

package orm_pkg;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int PIXEL_BITS_DEF = 32;

    // fixed field widths
    localparam int PIXEL_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ORIENT_W = 4;
    localparam int SIZE_W   = 9;
    localparam int CFG_IDX_W = 2;

    // command codes of the request word
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // orientation codes
    localparam logic [ORIENT_W-1:0] ORIENT_UP            = 4'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_UP_MIRRORED   = 4'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_BOTTOM        = 4'd3;
    localparam logic [ORIENT_W-1:0] ORIENT_BOTTOM_MIRROR = 4'd4;
    localparam logic [ORIENT_W-1:0] ORIENT_LEFT_MIRRORED = 4'd5;
    localparam logic [ORIENT_W-1:0] ORIENT_RIGHT         = 4'd6;
    localparam logic [ORIENT_W-1:0] ORIENT_RIGHT_MIRROR  = 4'd7;
    localparam logic [ORIENT_W-1:0] ORIENT_LEFT          = 4'd8;

    // reset values of the registers
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_READY = 2'd1,
        STATUS_ERROR     = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    push_write;
        logic    set_result;
        status_t result_code;
        logic    calc_addr;
        logic    load_pixel;
    } orm_cmd_t;

    // datapath to controller, valid while an item is held
    typedef struct packed {
        logic is_pull;
        logic err;
        logic not_ready;
    } orm_stat_t;

endpackage

### rtl/core/orm_req_if.sv
// orm_req_if: request channel (push or pull word) with valid/ready
// depends on orm_pkg for field widths

interface orm_req_if
    import orm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

### rtl/core/orm_rsp_if.sv
// orm_rsp_if: result channel with valid/ready
// depends on orm_pkg for field widths

interface orm_rsp_if
    import orm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PIXEL_W-1:0]  pixel_out;
    logic                row_end;
    logic                frame_end;

    modport source (output valid, output status, output pixel_out, output row_end,
                    output frame_end, input ready);
    modport sink   (input valid, input status, input pixel_out, input row_end,
                    input frame_end, output ready);
endinterface

### rtl/core/orm_cfg_if.sv
// orm_cfg_if: register write channel with valid/ready, index and data
// depends on orm_pkg for field widths

interface orm_cfg_if
    import orm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/orm_ram.sv
// orm_ram: generic single-port ram, write and registered read
// no dependencies

module orm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/orm_ctrl.sv
// orm_ctrl: sequencer for one word at a time (decide, address, read, present)
// depends on orm_pkg for command and status structs

module orm_ctrl
    import orm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  orm_stat_t stat,
    output orm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ADDR,
        S_READ,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.result_code = STATUS_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.err)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = STATUS_ERROR;
                    state_next      = S_OUT;
                end
                else if (!stat.is_pull)
                begin
                    cmd.push_write  = 1'b1;
                    cmd.set_result  = 1'b1;
                    cmd.result_code = STATUS_OK;
                    state_next      = S_OUT;
                end
                else if (stat.not_ready)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = STATUS_NOT_READY;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.calc_addr = 1'b1;
                    state_next    = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.load_pixel = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_OUT);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/orm_dpath.sv
// orm_dpath: registers, frame counters, address arithmetic and frame store
// depends on orm_pkg and orm_ram

module orm_dpath
    import orm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  orm_cmd_t             cmd,
    output orm_stat_t            stat,
    input  logic                 item_cmd,
    input  logic [PIXEL_W-1:0]   item_pixel,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output logic [STATUS_W-1:0]  res_status,
    output logic [PIXEL_W-1:0]   res_pixel,
    output logic                 res_row_end,
    output logic                 res_frame_end
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_WIDTH + 1);
    localparam int SH    = $clog2(MAX_HEIGHT + 1);
    localparam int SD    = (SW > SH) ? SW : SH;
    localparam int SB    = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;

    // registers
    logic [ORIENT_W-1:0] orient_reg;
    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [SW-1:0]       in_col_reg;
    logic [SH-1:0]       rows_done_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [SD-1:0]       out_row_reg, out_col_reg;
    logic                cmd_reg;
    logic [SB-1:0]       pix_reg;
    logic [AW-1:0]       prod_reg;
    logic [SW-1:0]       sc_reg;
    logic                re_pend_reg, fe_pend_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [PIXEL_W-1:0]  pixel_out_reg;
    logic                row_end_reg, frame_end_reg;

    logic [SW-1:0]       w_eff;
    logic [SH-1:0]       h_eff;
    logic [SD-1:0]       w_ext, h_ext, ow, oh, sr_full, sc_full;
    logic [SH-1:0]       sr;
    logic [SW-1:0]       sc;
    logic [SH+SW-1:0]    prod_full;
    logic                quarter, full, started, bad_orient, re, fe, restart;
    logic [AW-1:0]       ram_addr;
    logic [SB-1:0]       ram_rdata;

    // size clamp: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = SW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = SW'(MAX_WIDTH);
        else
            w_eff = SW'(width_reg);
        if (height_reg == '0)
            h_eff = SH'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = SH'(MAX_HEIGHT);
        else
            h_eff = SH'(height_reg);
    end

    assign w_ext      = SD'(w_eff);
    assign h_ext      = SD'(h_eff);
    assign quarter    = (orient_reg >= ORIENT_LEFT_MIRRORED) && (orient_reg <= ORIENT_LEFT);
    assign ow         = quarter ? h_ext : w_ext;
    assign oh         = quarter ? w_ext : h_ext;
    assign full       = (rows_done_reg == h_eff);
    assign started    = (out_row_reg != '0) || (out_col_reg != '0);
    assign bad_orient = (orient_reg < ORIENT_UP_MIRRORED) || (orient_reg > ORIENT_LEFT);

    always_comb
    begin
        stat.is_pull = (cmd_reg == CMD_PULL);
        if (cmd_reg == CMD_PULL)
        begin
            stat.err = bad_orient || (out_row_reg >= oh);
            if (orient_reg == ORIENT_UP_MIRRORED)
                stat.not_ready = (SD'(rows_done_reg) <= out_row_reg);
            else
                stat.not_ready = !full;
        end
        else
        begin
            stat.err       = full || started;
            stat.not_ready = 1'b0;
        end
    end

    // source row and column for the current output position
    always_comb
    begin
        case (orient_reg)
            ORIENT_UP_MIRRORED:
            begin
                sr_full = out_row_reg;
                sc_full = w_ext - SD'(1) - out_col_reg;
            end
            ORIENT_BOTTOM:
            begin
                sr_full = h_ext - SD'(1) - out_row_reg;
                sc_full = w_ext - SD'(1) - out_col_reg;
            end
            ORIENT_BOTTOM_MIRROR:
            begin
                sr_full = h_ext - SD'(1) - out_row_reg;
                sc_full = out_col_reg;
            end
            ORIENT_LEFT_MIRRORED:
            begin
                sr_full = out_col_reg;
                sc_full = out_row_reg;
            end
            ORIENT_RIGHT:
            begin
                sr_full = h_ext - SD'(1) - out_col_reg;
                sc_full = out_row_reg;
            end
            ORIENT_RIGHT_MIRROR:
            begin
                sr_full = h_ext - SD'(1) - out_col_reg;
                sc_full = w_ext - SD'(1) - out_row_reg;
            end
            default:
            begin
                sr_full = out_col_reg;
                sc_full = w_ext - SD'(1) - out_row_reg;
            end
        endcase
    end

    assign sr        = SH'(sr_full);
    assign sc        = SW'(sc_full);
    assign prod_full = {{SW{1'b0}}, sr} * {{SH{1'b0}}, w_eff};
    assign re        = ((out_col_reg + SD'(1)) == ow);
    assign fe        = re && ((out_row_reg + SD'(1)) == oh);
    assign restart   = cfg_valid && (cfg_index <= CFG_IMAGE_HEIGHT);

    // config and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg    <= ORIENT_UP;
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
            in_col_reg    <= '0;
            rows_done_reg <= '0;
            wr_addr_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else if (restart)
        begin
            case (cfg_index)
                CFG_ORIENTATION:  orient_reg <= cfg_data[ORIENT_W-1:0];
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                default:          height_reg <= cfg_data;
            endcase
            in_col_reg    <= '0;
            rows_done_reg <= '0;
            wr_addr_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            if (cmd.push_write)
            begin
                wr_addr_reg <= wr_addr_reg + AW'(1);
                if ((in_col_reg + SW'(1)) == w_eff)
                begin
                    in_col_reg    <= '0;
                    rows_done_reg <= rows_done_reg + SH'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + SW'(1);
                end
            end
            if (cmd.calc_addr)
            begin
                if (re)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + SD'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + SD'(1);
                end
            end
        end
    end

    // item, address and result words
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg <= item_cmd;
            pix_reg <= item_pixel[SB-1:0];
        end
        if (cmd.calc_addr)
        begin
            prod_reg    <= prod_full[AW-1:0];
            sc_reg      <= sc;
            re_pend_reg <= re;
            fe_pend_reg <= fe;
        end
        if (cmd.set_result)
        begin
            status_reg    <= cmd.result_code;
            pixel_out_reg <= '0;
            row_end_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else if (cmd.load_pixel)
        begin
            status_reg    <= STATUS_OK;
            pixel_out_reg <= PIXEL_W'(ram_rdata);
            row_end_reg   <= re_pend_reg;
            frame_end_reg <= fe_pend_reg;
        end
    end

    assign ram_addr = cmd.push_write ? wr_addr_reg : (prod_reg + AW'(sc_reg));

    orm_ram #(
        .WIDTH     (SB),
        .DEPTH     (DEPTH),
        .ADDR_BITS (AW)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push_write),
        .addr  (ram_addr),
        .wdata (pix_reg),
        .rdata (ram_rdata)
    );

    assign res_status    = status_reg;
    assign res_pixel     = pixel_out_reg;
    assign res_row_end   = row_end_reg;
    assign res_frame_end = frame_end_reg;

endmodule

### rtl/core/orientation_rotate_mirror_buffer.sv
// orientation_rotate_mirror_buffer: top level of the rotate/mirror frame buffer
// depends on orm_pkg, the three channel interfaces, orm_ctrl, orm_dpath and orm_ram
//
// usage
//   req: one word per push (cmd 0, pixel_in in raster order) or pull (cmd 1)
//   rsp: exactly one word per request: status, pixel_out, row_end, frame_end
//   cfg: register writes (0 orientation, 1 width, 2 height); always ready,
//        any write to a listed register restarts the frame
// timing
//   one request at a time; req ready is high only while the block is idle
//   push or any error / not-ready answer: steps accept, decide, present
//   ok pull: steps accept, decide, address multiply, store read, present;
//   the store is a single-port ram with registered read, and the
//   row-times-width product is registered before it addresses the ram
//   the response word is registered and appears once the block enters present
// reset
//   counters clear and the registers take orientation up, 256 x 256; the
//   frame store keeps no reset state and needs no clearing pass
// stalls
//   the response word holds until rsp ready; no new request is taken meanwhile

module orientation_rotate_mirror_buffer
    import orm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    orm_req_if.sink   req,
    orm_rsp_if.source rsp,
    orm_cfg_if.sink   cfg
);

    orm_cmd_t  cmd;
    orm_stat_t stat;

    // config writes must land only while idle; the block does not enforce it
    assign cfg.ready = 1'b1;

    // sequencer
    orm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // counters, address arithmetic and frame store
    orm_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_cmd      (req.cmd),
        .item_pixel    (req.pixel_in),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .res_status    (rsp.status),
        .res_pixel     (rsp.pixel_out),
        .res_row_end   (rsp.row_end),
        .res_frame_end (rsp.frame_end)
    );

endmodule
